[rtl/mths_pkg.sv]
// Package for the multilevel tagged hash set: sizes, mix32 hash constants,
// register indexes and the controller state type. No dependencies.
package mths_pkg;

  localparam int LEVELS      = 6;
  localparam int BASE_SLOTS  = 256;
  localparam int MAX_HASHES  = 4;
  localparam int TOTAL_SLOTS = BASE_SLOTS * ((1 << LEVELS) - 1);
  localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
  localparam int LV_W        = $clog2(LEVELS + 1);
  localparam int HI_W        = 2;
  localparam int LINE_W      = 4;
  localparam int LINE_LOG_MAX = 4;
  localparam int TAG_W       = 16;
  localparam int KEY_W       = 32;
  localparam int ENTRY_W     = 1 + TAG_W + KEY_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // mix32 hash constants
  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_C3 = 32'h85ebca6b;
  localparam logic [31:0] MM_C4 = 32'hc2b2ae35;
  localparam logic [31:0] MM_N  = 32'he6546b64;
  localparam logic [31:0] MM_M5 = 32'd5;
  localparam logic [31:0] MM_LEN = 32'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LOG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEED3      = 3'd5;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_HASH  = 6'b000100,
    ST_PROBE = 6'b001000,
    ST_CMP   = 6'b010000,
    ST_OUT   = 6'b100000
  } ctl_state_t;

  typedef enum logic [6:0] {
    HS_IDLE = 7'b0000001,
    HS_S0   = 7'b0000010,
    HS_S1   = 7'b0000100,
    HS_S2   = 7'b0001000,
    HS_S3   = 7'b0010000,
    HS_S4   = 7'b0100000,
    HS_S5   = 7'b1000000
  } hash_state_t;

endpackage

[rtl/multilevel_tagged_hash_set_core.sv]
// Top level of the multilevel tagged hash set: controller, config registers,
// slot memory and hash unit. Depends on mths_pkg, mths_hash, mths_ram.
//
// After reset the block clears its slot memory, one slot a cycle, across all
// TOTAL_SLOTS (16128) slots with in_stall high; config writes are taken
// meanwhile. Each item then runs one seeded hash after another on the shared
// murmur3 multiplier, then probes slot by slot (one slot-memory read and
// one compare per slot probed), then issues the result from ST_OUT.
// The block takes one item at a time.
module multilevel_tagged_hash_set_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [31:0]                      in_key,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_present,
  output logic                             out_added,
  output logic                             out_no_room,
  input  logic                             cfg_we,
  input  logic [mths_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mths_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mths_pkg::*;

  ctl_state_t state_r;

  // configuration registers
  logic [2:0]  hash_count_r;
  logic [2:0]  line_log_r;
  logic [31:0] seed_r [MAX_HASHES];

  // item context
  logic              key_ins_r;
  logic [31:0]       key_r;
  logic [HI_W-1:0]   hl_r, hi_r;
  logic [31:0]       h_r [MAX_HASHES];
  logic [TAG_W-1:0]  tag_r;
  logic [LV_W-1:0]   j_r, levels_r;
  logic [ADDR_W-1:0] base_r, size_r, addr_r, clr_r;
  logic [LINE_W-1:0] c_r, rmask_r;
  logic              ext_r;
  logic              res_pres_r, res_add_r, res_nr_r;
  logic              out_valid_r, out_pres_r, out_add_r, out_nr_r;

  // hash unit
  logic        h_start, h_done;
  logic [31:0] h_val;

  // memory
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, probe_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic              accept;
  logic [2:0]        hc_eff;
  logic [2:0]        ll_eff;
  logic [HI_W-1:0]   hl_eff;
  logic [LINE_W-1:0] off;
  logic [31:0]       h_sel;
  logic              e_valid, e_match, line_end, hash_end, lvl_end;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // clamp hash count and line size
  always_comb begin
    hc_eff = hash_count_r;
    if (hc_eff < 3'd1) hc_eff = 3'd1;
    if (hc_eff > 3'(MAX_HASHES)) hc_eff = 3'(MAX_HASHES);
    hl_eff = HI_W'(hc_eff - 3'd1);
    ll_eff = (line_log_r > 3'(LINE_LOG_MAX)) ? 3'(LINE_LOG_MAX) : line_log_r;
  end

  // form the probe address of the current slot
  always_comb begin
    h_sel      = h_r[hi_r];
    off        = (tag_r[LINE_W-1:0] + c_r) & rmask_r;
    probe_addr = base_r
               + ((h_sel[ADDR_W-1:0] & (size_r - ADDR_W'(1))) & ~ADDR_W'(rmask_r))
               + ADDR_W'(off);
  end

  assign e_valid  = ram_rdata[ENTRY_W-1];
  assign e_match  = (ram_rdata[KEY_W +: TAG_W] == tag_r) && (ram_rdata[KEY_W-1:0] == key_r);
  assign line_end = (c_r == rmask_r);
  assign hash_end = (hi_r == hl_r);
  assign lvl_end  = (j_r + LV_W'(1) == levels_r);

  assign h_start = (accept) || (state_r == ST_HASH && h_done && !hash_end);

  // write port: clearing pass or new entry
  assign ram_we    = (state_r == ST_CLEAR) || (state_r == ST_CMP && !e_valid && key_ins_r);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_r : addr_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : {1'b1, tag_r, key_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_count_r <= 3'd2;
      line_log_r   <= 3'd3;
      seed_r[0]    <= 32'd0;
      seed_r[1]    <= 32'd1;
      seed_r[2]    <= 32'd2;
      seed_r[3]    <= 32'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HASH_COUNT: hash_count_r <= cfg_data[2:0];
        REG_LINE_LOG:   line_log_r   <= cfg_data[2:0];
        REG_SEED0:      seed_r[0]    <= cfg_data;
        REG_SEED1:      seed_r[1]    <= cfg_data;
        REG_SEED2:      seed_r[2]    <= cfg_data;
        REG_SEED3:      seed_r[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: hash, then probe slot by slot across hashes and levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      levels_r    <= LV_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_OUT) out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + ADDR_W'(1);
          if (clr_r == ADDR_W'(TOTAL_SLOTS - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            key_r     <= in_key;
            key_ins_r <= in_req_type;
            hl_r      <= hl_eff;
            hi_r      <= '0;
            rmask_r   <= LINE_W'((5'd1 << ll_eff) - 5'd1);
            state_r   <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (h_done) begin
            h_r[hi_r] <= h_val;
            if (hi_r == '0) tag_r <= h_val[TAG_W-1:0] ^ h_val[31:16];
            if (hash_end) begin
              hi_r       <= '0;
              j_r        <= '0;
              c_r        <= '0;
              base_r     <= '0;
              size_r     <= ADDR_W'(BASE_SLOTS);
              ext_r      <= 1'b0;
              res_pres_r <= 1'b0;
              res_add_r  <= 1'b0;
              res_nr_r   <= 1'b0;
              state_r    <= ST_PROBE;
            end else begin
              hi_r <= hi_r + HI_W'(1);
            end
          end
        end
        ST_PROBE: begin
          addr_r  <= probe_addr;
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          state_r <= ST_PROBE;
          if (!e_valid) begin
            res_add_r <= key_ins_r;
            state_r   <= ST_OUT;
          end else if (e_match) begin
            res_pres_r <= 1'b1;
            state_r    <= ST_OUT;
          end else if (!line_end) begin
            c_r <= c_r + LINE_W'(1);
          end else begin
            c_r <= '0;
            if (!hash_end) begin
              hi_r <= hi_r + HI_W'(1);
            end else begin
              hi_r <= '0;
              if (!lvl_end) begin
                j_r    <= j_r + LV_W'(1);
                base_r <= base_r + size_r;
                size_r <= size_r << 1;
              end else if (!key_ins_r || ext_r) begin
                state_r <= ST_OUT;
              end else if (levels_r != LV_W'(LEVELS)) begin
                // open one more level and probe it
                levels_r <= levels_r + LV_W'(1);
                ext_r    <= 1'b1;
                j_r      <= j_r + LV_W'(1);
                base_r   <= base_r + size_r;
                size_r   <= size_r << 1;
              end else begin
                res_nr_r <= 1'b1;
                state_r  <= ST_OUT;
              end
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_pres_r  <= res_pres_r;
            out_add_r   <= res_add_r;
            out_nr_r    <= res_nr_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_present = out_pres_r;
  assign out_added   = out_add_r;
  assign out_no_room = out_nr_r;

  mths_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (h_start),
    .key   (accept ? in_key : key_r),
    .seed  (seed_r[accept ? HI_W'(0) : (h_done ? hi_r + HI_W'(1) : hi_r)]),
    .done  (h_done),
    .hash  (h_val)
  );

  mths_ram #(
    .DEPTH (TOTAL_SLOTS),
    .WIDTH (ENTRY_W)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (probe_addr),
    .rdata (ram_rdata)
  );

endmodule

[rtl/mths_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mths_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mths_hash.sv]
// Mix32 hash of one 32-bit word, six steps over one shared multiplier.
// Depends on mths_pkg.
module mths_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] key,
  input  logic [31:0] seed,
  output logic        done,
  output logic [31:0] hash
);
  import mths_pkg::*;

  hash_state_t state_r, state_nxt;
  logic [31:0] x_r, x_nxt;
  logic [31:0] mul_a, mul_b, t0, t1;
  logic [31:0] prod;

  // select multiplier operands and the next accumulator value
  always_comb begin
    mul_a     = x_r;
    mul_b     = MM_C1;
    t0        = 32'd0;
    t1        = 32'd0;
    x_nxt     = x_r;
    state_nxt = state_r;
    prod      = mul_a * mul_b;
    case (state_r)
      HS_IDLE: begin
        if (start) state_nxt = HS_S0;
      end
      HS_S0: begin
        mul_a = key;
        mul_b = MM_C1;
        prod  = mul_a * mul_b;
        x_nxt = prod;
        state_nxt = HS_S1;
      end
      HS_S1: begin
        mul_a = {x_r[16:0], x_r[31:17]};
        mul_b = MM_C2;
        prod  = mul_a * mul_b;
        x_nxt = prod;
        state_nxt = HS_S2;
      end
      HS_S2: begin
        t0    = seed ^ x_r;
        mul_a = {t0[18:0], t0[31:19]};
        mul_b = MM_M5;
        prod  = mul_a * mul_b;
        x_nxt = prod + MM_N;
        state_nxt = HS_S3;
      end
      HS_S3: begin
        t0    = x_r ^ MM_LEN;
        t1    = t0 ^ (t0 >> 16);
        mul_a = t1;
        mul_b = MM_C3;
        prod  = mul_a * mul_b;
        x_nxt = prod;
        state_nxt = HS_S4;
      end
      HS_S4: begin
        mul_a = x_r ^ (x_r >> 13);
        mul_b = MM_C4;
        prod  = mul_a * mul_b;
        x_nxt = prod;
        state_nxt = HS_S5;
      end
      HS_S5: begin
        state_nxt = start ? HS_S0 : HS_IDLE;
      end
      default: state_nxt = HS_IDLE;
    endcase
  end

  assign done = (state_r == HS_S5);
  assign hash = x_r ^ (x_r >> 16);

  // advance the step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    x_r <= x_nxt;
  end

endmodule

[rtl/mths_checker.sv]
// Port-level assertions for multilevel_tagged_hash_set_core, bound to the top.
// No dependencies.
module mths_props (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_present,
  input logic out_added,
  input logic out_no_room
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable({out_present, out_added, out_no_room}))
    else $error("stalled result changed");

  // at most one outcome flag per result
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_present, out_added, out_no_room}))
    else $error("conflicting result flags");

  // reset starts the clearing pass with no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block ready or result pending after reset");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("ready right after accepting an item");

endmodule

bind multilevel_tagged_hash_set_core mths_props u_mths_props (.*);

[verif/mths_checker.sv]
// Checker for the multilevel tagged hash set: watches the request, result and
// register ports, predicts each result and compares it. Depends on mths_pkg.
module mths_checker
  import mths_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [31:0]           in_key,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_present,
  input  logic                  out_added,
  input  logic                  out_no_room,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic present;
    logic added;
    logic no_room;
  } verdict_t;

  // Shadow copy of the set and its registers
  logic [ENTRY_W-1:0] shadow_slots [TOTAL_SLOTS];
  int                 open_levels;
  logic [2:0]         hash_cnt;
  logic [2:0]         line_log;
  logic [31:0]        seed [4];
  verdict_t           verdict_q [$];
  int                 fails;

  // mix32 hash of one little-endian 32-bit word
  function automatic logic [31:0] mix_hash(logic [31:0] key, logic [31:0] sd);
    logic [31:0] k;
    logic [31:0] h;
    k = key * MM_C1;
    k = {k[16:0], k[31:17]};
    k = k * MM_C2;
    h = sd ^ k;
    h = {h[18:0], h[31:19]};
    h = h * MM_M5 + MM_N;
    h = h ^ MM_LEN;
    h = h ^ (h >> 16);
    h = h * MM_C3;
    h = h ^ (h >> 13);
    h = h * MM_C4;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // Scan one aligned line: 0 empty slot found, 1 key found, 2 neither
  function automatic int scan_line(int lvl, logic [31:0] h, logic [15:0] tag,
                                   logic [31:0] key, int r, output int where);
    logic [31:0]        start;
    logic [ENTRY_W-1:0] e;
    int                 idx;
    where = 0;
    start = h & ((BASE_SLOTS << lvl) - 1) & ~(r - 1);
    for (int c = 0; c < r; c++) begin
      idx = BASE_SLOTS * ((1 << lvl) - 1) + int'(start) + int'((tag + c) & (r - 1));
      if (idx >= TOTAL_SLOTS) return 2;
      e = shadow_slots[idx];
      if (!e[ENTRY_W-1]) begin
        where = idx;
        return 0;
      end
      if (e[47:32] == tag && e[31:0] == key) return 1;
    end
    return 2;
  endfunction

  // Look up or insert one key and return the expected verdict
  function automatic verdict_t lookup_key(logic ins, logic [31:0] key);
    int          hc;
    int          r;
    int          res;
    int          where;
    int          lv;
    logic [31:0] h [4];
    logic [15:0] tag;
    logic        done;
    verdict_t    v;
    v = '0;
    done = 1'b0;
    hc = (hash_cnt < 1) ? 1 : (hash_cnt > MAX_HASHES) ? MAX_HASHES : int'(hash_cnt);
    r = 1 << ((line_log > 4) ? 4 : int'(line_log));
    for (int i = 0; i < hc; i++) h[i] = mix_hash(key, seed[i]);
    tag = h[0][15:0] ^ h[0][31:16];
    for (int j = 0; j < open_levels && !done; j++) begin
      for (int i = 0; i < hc && !done; i++) begin
        res = scan_line(j, h[i], tag, key, r, where);
        if (res == 1) begin
          v.present = 1'b1;
          done = 1'b1;
        end else if (res == 0) begin
          if (ins) begin
            shadow_slots[where] = {1'b1, tag, key};
            v.added = 1'b1;
          end
          done = 1'b1;
        end
      end
    end
    // Open one more level, or report a full set
    if (!done && ins) begin
      if (open_levels < LEVELS) begin
        lv = open_levels;
        open_levels = lv + 1;
        for (int i = 0; i < hc && !done; i++) begin
          if (scan_line(lv, h[i], tag, key, r, where) == 0) begin
            shadow_slots[where] = {1'b1, tag, key};
            v.added = 1'b1;
            done = 1'b1;
          end
        end
      end else begin
        v.no_room = 1'b1;
      end
    end
    return v;
  endfunction

  // Track registers, predict on each accepted item, compare each result
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      for (int s = 0; s < TOTAL_SLOTS; s++) shadow_slots[s] = '0;
      open_levels = 1;
      hash_cnt = 3'd2;
      line_log = 3'd3;
      for (int s = 0; s < 4; s++) seed[s] = 32'(s);
      verdict_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HASH_COUNT: hash_cnt = cfg_data[2:0];
          REG_LINE_LOG:   line_log = cfg_data[2:0];
          REG_SEED0:      seed[0] = cfg_data;
          REG_SEED1:      seed[1] = cfg_data;
          REG_SEED2:      seed[2] = cfg_data;
          REG_SEED3:      seed[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) verdict_q.push_back(lookup_key(in_req_type, in_key));
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = verdict_q.pop_front();
          if (out_present !== want.present) begin
            $error("present: expected %0b, got %0b", want.present, out_present);
            fails++;
          end
          if (out_added !== want.added) begin
            $error("added: expected %0b, got %0b", want.added, out_added);
            fails++;
          end
          if (out_no_room !== want.no_room) begin
            $error("no_room: expected %0b, got %0b", want.no_room, out_no_room);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending <= verdict_q.size();
  end

endmodule

[verif/tb.sv]
// Testbench top for the multilevel tagged hash set: clock, reset, request and
// register stimulus, result stalls and verdict. Depends on mths_pkg, mths_checker.
module tb;
  import mths_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 110;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_req_type;
  logic [31:0]           in_key;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_present;
  logic                  out_added;
  logic                  out_no_room;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  int                    cycles = 0;
  int                    sent;
  int                    results;
  bit                    idle_on;
  logic [31:0]           key_pool [64];
  logic [2:0]            hc_set [PHASES] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd5, 3'd3, 3'd2};
  logic [2:0]            ll_set [PHASES] = '{3'd0, 3'd4, 3'd1, 3'd7, 3'd2, 3'd6, 3'd3};

  multilevel_tagged_hash_set_core u_top (.*);

  mths_checker u_chk (.*);

  // 12-unit clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one item, after an optional gap, and hold it until accepted
  task automatic send_item(logic ins, logic [31:0] key);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= ins;
    in_key <= key;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [2:0] hc, logic [2:0] ll, logic [31:0] s0,
                          logic [31:0] s1, logic [31:0] s2, logic [31:0] s3);
    write_reg(REG_HASH_COUNT, {29'd0, hc});
    write_reg(REG_LINE_LOG, {29'd0, ll});
    write_reg(REG_SEED0, s0);
    write_reg(REG_SEED1, s1);
    write_reg(REG_SEED2, s2);
    write_reg(REG_SEED3, s3);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls after each result, one long hold-off
  initial begin
    int gap;
    out_stall <= 1'b0;
    results = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        results++;
        gap = (results == 150) ? 2500 : idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Request stimulus and verdict
  initial begin
    logic [31:0] k;
    logic [31:0] s0;
    sent = 0;
    idle_on = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= 1'b0;
    in_key <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    for (int i = 0; i < 64; i++) key_pool[i] = $urandom();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme keys, absent and present, under reset registers
    send_item(1'b0, 32'h0);
    send_item(1'b0, 32'hffffffff);
    send_item(1'b1, 32'h0);
    send_item(1'b1, 32'hffffffff);
    send_item(1'b0, 32'h0);
    send_item(1'b1, 32'h0);
    send_item(1'b0, 32'hffffffff);
    send_item(1'b1, 32'h80000001);
    send_item(1'b0, 32'h7fffffff);
    send_item(1'b1, 32'h55555555);
    send_item(1'b1, 32'haaaaaaaa);
    send_item(1'b0, 32'haaaaaaaa);
    drain();

    // Random phases across register settings, saturating values among them
    for (int p = 0; p < PHASES; p++) begin
      set_regs(hc_set[p], ll_set[p], (p == 1) ? 32'h0 : $urandom(),
               (p == 1) ? 32'hffffffff : $urandom(), $urandom(),
               (p == 6) ? 32'hffffffff : $urandom());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 30 == 0) idle_on = $urandom_range(0, 2) != 0;
        k = ($urandom_range(0, 9) < 6) ? key_pool[$urandom_range(0, 63)] : $urandom();
        send_item(1'($urandom_range(0, 1)), k);
        if ($urandom_range(0, 7) == 0) key_pool[$urandom_range(0, 63)] = k;
      end
      drain();
    end

    // Fill slot 0 of every level with keys that share it, then overflow
    s0 = $urandom();
    set_regs(3'd1, 3'd0, s0, $urandom(), $urandom(), $urandom());
    idle_on = 1'b1;
    for (int n = 0; n < 9; n++) begin
      do k = $urandom(); while (u_chk.mix_hash(k, s0) & 32'h1fff);
      send_item(1'b1, k);
      send_item(1'b0, k);
    end
    drain();

    $display("Sent %0d items over %0d register settings; %0d results checked,",
             sent, PHASES + 2, results);
    $display("with one long result hold-off and a drain between settings.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mths_pkg.sv
rtl/mths_ram.sv
rtl/mths_hash.sv
rtl/multilevel_tagged_hash_set_core.sv
rtl/mths_checker.sv
verif/mths_checker.sv
verif/tb.sv
